>>> rtl/svpwm_pkg.sv
// Shared types, constants and helpers for the servo PWM generator.
// No dependencies; used by every module in rtl/.
`default_nettype none

package svpwm_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int NUM_GROUPS   = 3;
  localparam int NUM_PERIODS  = 3;
  localparam int GROUP_SIZE   = 3;
  localparam int COUNT_WIDTH  = 16;
  localparam int PINS_W       = 8;

  localparam int ACT_W     = 3;
  localparam int CH_W      = 3;
  localparam int VAL_W     = 16;
  localparam int CMP_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam int CMD_MAX     = 1024;
  localparam int CMD_W       = 11;
  localparam int SCALE_SHIFT = 10;

  localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd40000;
  localparam logic [CFG_W-1:0] MIN_RESET    = 16'd1800;
  localparam logic [CFG_W-1:0] SPAN_RESET   = 16'd2400;

  typedef logic [ACT_W-1:0] action_t;
  localparam action_t ACT_TICK    = 3'd0;
  localparam action_t ACT_SET_ONE = 3'd1;
  localparam action_t ACT_SET_ALL = 3'd2;
  localparam action_t ACT_EN_ONE  = 3'd3;
  localparam action_t ACT_EN_ALL  = 3'd4;

  typedef logic [CFG_IDX_W-1:0] reg_index_t;
  localparam reg_index_t REG_PERIOD0 = 3'd0;
  localparam reg_index_t REG_PERIOD1 = 3'd1;
  localparam reg_index_t REG_PERIOD2 = 3'd2;
  localparam reg_index_t REG_MIN     = 3'd3;
  localparam reg_index_t REG_SPAN    = 3'd4;

  typedef logic [NUM_PERIODS-1:0][CFG_W-1:0] periods_t;

  typedef struct packed {
    logic             fire;
    action_t          action;
    logic [CH_W-1:0]  channel;
    logic             enable;
    logic [CMP_W-1:0] pulse;
  } cmd_t;

  function automatic int group_of(int ch);
    int g;
    g = ch / GROUP_SIZE;
    return (g >= NUM_GROUPS) ? NUM_GROUPS - 1 : g;
  endfunction

  function automatic int period_sel(int g);
    return (g < NUM_PERIODS) ? g : NUM_PERIODS - 1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/svpwm_scale.sv
// Command scaler: clamp a signed command, scale it by the span, add the base width.
// Depends on svpwm_pkg.
`default_nettype none

module svpwm_scale (
  input  wire logic signed [svpwm_pkg::VAL_W-1:0] value,
  input  wire logic        [svpwm_pkg::CFG_W-1:0] min_width,
  input  wire logic        [svpwm_pkg::CFG_W-1:0] width_span,
  output logic             [svpwm_pkg::CMP_W-1:0] pulse
);

  localparam int PROD_W = svpwm_pkg::CMD_W + svpwm_pkg::CFG_W;
  localparam int SCL_W  = PROD_W - svpwm_pkg::SCALE_SHIFT;
  localparam int SUM_W  = SCL_W + 1;

  logic [svpwm_pkg::CMD_W-1:0] clamped;
  logic [PROD_W-1:0]           product;
  logic [SCL_W-1:0]            scaled;
  logic [SUM_W-1:0]            total;

  always_comb begin
    if (value < 0) begin
      clamped = '0;
    end else if (value > $signed(svpwm_pkg::VAL_W'(svpwm_pkg::CMD_MAX))) begin
      clamped = svpwm_pkg::CMD_W'(svpwm_pkg::CMD_MAX);
    end else begin
      clamped = value[svpwm_pkg::CMD_W-1:0];
    end
    product = PROD_W'(clamped) * PROD_W'(width_span);
    scaled  = product[PROD_W-1:svpwm_pkg::SCALE_SHIFT];
    total   = SUM_W'(min_width) + SUM_W'(scaled);
    if (total[SUM_W-1:svpwm_pkg::CMP_W] != '0) begin
      pulse = '1;
    end else begin
      pulse = total[svpwm_pkg::CMP_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/svpwm_core.sv
// Timer groups, compare registers and channel enables; gives pin levels after a command.
// Depends on svpwm_pkg.
`default_nettype none

module svpwm_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire svpwm_pkg::cmd_t       cmd,
  input  wire svpwm_pkg::periods_t   periods,
  output logic [svpwm_pkg::PINS_W-1:0] pins_next
);

  localparam int CW = svpwm_pkg::COUNT_WIDTH;
  localparam int NC = svpwm_pkg::NUM_CHANNELS;
  localparam int NG = svpwm_pkg::NUM_GROUPS;
  localparam int MW = (CW > svpwm_pkg::CMP_W) ? CW : svpwm_pkg::CMP_W;

  logic [NG-1:0][CW-1:0]               count;
  logic [NG-1:0][CW-1:0]               count_next;
  logic [NG-1:0]                       wrap;
  logic [NC-1:0][svpwm_pkg::CMP_W-1:0] pending;
  logic [NC-1:0][svpwm_pkg::CMP_W-1:0] pending_next;
  logic [NC-1:0][svpwm_pkg::CMP_W-1:0] active;
  logic [NC-1:0][svpwm_pkg::CMP_W-1:0] active_next;
  logic [NC-1:0]                       on;
  logic [NC-1:0]                       on_next;
  logic [NC-1:0]                       pin;

  logic is_tick, set_one, set_all, en_one, en_all;

  always_comb begin
    is_tick = 1'b0;
    set_one = 1'b0;
    set_all = 1'b0;
    en_one  = 1'b0;
    en_all  = 1'b0;
    case (cmd.action)
      svpwm_pkg::ACT_TICK:    is_tick = 1'b1;
      svpwm_pkg::ACT_SET_ONE: set_one = 1'b1;
      svpwm_pkg::ACT_SET_ALL: set_all = 1'b1;
      svpwm_pkg::ACT_EN_ONE:  en_one  = 1'b1;
      svpwm_pkg::ACT_EN_ALL:  en_all  = 1'b1;
      default: ;
    endcase
  end

  for (genvar g = 0; g < NG; g++) begin : g_group
    localparam int P = svpwm_pkg::period_sel(g);
    assign wrap[g] = is_tick && (count[g] >= CW'(periods[P]));
    assign count_next[g] = !is_tick ? count[g] :
                           wrap[g]  ? '0       : count[g] + CW'(1);
  end

  for (genvar c = 0; c < NC; c++) begin : g_chan
    localparam int G = svpwm_pkg::group_of(c);
    logic sel;
    assign sel = (cmd.channel == svpwm_pkg::CH_W'(c));
    assign pending_next[c] = (set_all || (set_one && sel)) ? cmd.pulse : pending[c];
    assign active_next[c]  = wrap[G] ? pending[c] : active[c];
    assign on_next[c]      = (en_all || (en_one && sel)) ? cmd.enable : on[c];
    assign pin[c] = on_next[c] && (MW'(count_next[G]) <= MW'(active_next[c]));
  end

  for (genvar i = 0; i < svpwm_pkg::PINS_W; i++) begin : g_pin
    if (i < NC) begin : g_used
      assign pins_next[i] = pin[i];
    end else begin : g_unused
      assign pins_next[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      pending <= '1;
      active  <= '1;
      on      <= '0;
    end else if (cmd.fire) begin
      count   <= count_next;
      pending <= pending_next;
      active  <= active_next;
      on      <= on_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/servo_pwm_generator.sv
// Eight-channel servo PWM generator in three timer groups (channels 0-2, 3-5, 6-7).
// A word is taken every clock cycle unless the result side stalls; its result word
// passes through one input register and one result register, and the per-word
// update of counters, compares and enables sets that rate. Each tick word advances
// every group counter once; set and enable words leave the counters alone. Pending
// compares take effect when their group wraps. The user must write registers
// through cfg_we/cfg_index/cfg_data only while no word is in flight; not enforced.
// Depends on svpwm_pkg, svpwm_scale and svpwm_core.
`default_nettype none

module servo_pwm_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // channel[2:0], value[18:3], enable[19], zero
  input  wire logic [2:0]  s_axis_tuser,  // action[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // pins[7:0], pulse_ticks[23:8]
  input  wire logic        cfg_we,
  input  wire logic [svpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [svpwm_pkg::CFG_W-1:0]     cfg_data
);

  svpwm_pkg::periods_t               periods;
  logic [svpwm_pkg::CFG_W-1:0]       min_width;
  logic [svpwm_pkg::CFG_W-1:0]       width_span;

  logic                              s1_valid;
  svpwm_pkg::action_t                s1_action;
  logic [svpwm_pkg::CH_W-1:0]        s1_channel;
  logic signed [svpwm_pkg::VAL_W-1:0] s1_value;
  logic                              s1_enable;

  logic [svpwm_pkg::PINS_W-1:0]      m_pins;
  logic [svpwm_pkg::CMP_W-1:0]       m_pulse;

  logic                              out_ready;
  logic                              s1_adv;
  logic                              in_accept;
  logic                              is_set;
  logic [svpwm_pkg::CMP_W-1:0]       scaled;
  logic [svpwm_pkg::CMP_W-1:0]       pulse;
  logic [svpwm_pkg::PINS_W-1:0]      pins_next;
  svpwm_pkg::cmd_t                   cmd;

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign s1_adv        = s1_valid && out_ready;
  assign s_axis_tready = !s1_valid || out_ready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {m_pulse, m_pins};

  always_ff @(posedge clk) begin
    if (rst) begin
      periods    <= {svpwm_pkg::NUM_PERIODS{svpwm_pkg::PERIOD_RESET}};
      min_width  <= svpwm_pkg::MIN_RESET;
      width_span <= svpwm_pkg::SPAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        svpwm_pkg::REG_PERIOD0: periods[0] <= cfg_data;
        svpwm_pkg::REG_PERIOD1: periods[1] <= cfg_data;
        svpwm_pkg::REG_PERIOD2: periods[2] <= cfg_data;
        svpwm_pkg::REG_MIN:     min_width  <= cfg_data;
        svpwm_pkg::REG_SPAN:    width_span <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action  <= s_axis_tuser;
      s1_channel <= s_axis_tdata[2:0];
      s1_value   <= s_axis_tdata[18:3];
      s1_enable  <= s_axis_tdata[19];
    end
  end

  svpwm_scale u_scale (
    .value      (s1_value),
    .min_width  (min_width),
    .width_span (width_span),
    .pulse      (scaled)
  );

  assign is_set = (s1_action == svpwm_pkg::ACT_SET_ONE) ||
                  (s1_action == svpwm_pkg::ACT_SET_ALL);
  assign pulse  = is_set ? scaled : '0;

  assign cmd.fire    = s1_adv;
  assign cmd.action  = s1_action;
  assign cmd.channel = s1_channel;
  assign cmd.enable  = s1_enable;
  assign cmd.pulse   = pulse;

  svpwm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .periods   (periods),
    .pins_next (pins_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_pins  <= pins_next;
      m_pulse <= pulse;
    end
  end

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_action) && $stable(s1_value)))
    else $error("held input word changed while result side stalled");

  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  a_pulse_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !is_set) |=> (m_axis_tdata[23:8] == '0))
    else $error("non-zero pulse for a word that sets no compare");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> (!m_axis_tvalid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
